// File: rtl/jtag_debug_word_master_assert.svh
// assertion macros used by the jtag debug word master checker
`ifndef JTAG_DEBUG_WORD_MASTER_ASSERT_SVH
`define JTAG_DEBUG_WORD_MASTER_ASSERT_SVH

// checked while out of reset
`define JDW_ASSERT(lbl, prp) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prp)) \
    else $error("jtag debug word master assertion failed");

// checked at every edge, reset included
`define JDW_ASSERT_ALWAYS(lbl, prp) \
  lbl: assert property (@(posedge clk_i) (prp)) \
    else $error("jtag debug word master assertion failed");

`endif

// File: rtl/jdw_pkg.sv
// types, codes and constants of the jtag debug word master
package jdw_pkg;

  localparam int unsigned IrLengthDefault = 5;
  localparam int unsigned DataBitsDefault = 32;

  localparam logic [4:0]  IdcodeOpcodeReset = 5'd30;
  localparam logic [5:0]  InvalidInstr      = 6'h3F;

  localparam logic [31:0] ManufMask  = 32'hFFF0_0000;
  localparam logic [31:0] ManufValue = 32'hC800_0000;
  localparam logic [31:0] PartMask   = 32'h000F_FFF0;
  localparam logic [31:0] PartValue  = 32'h0002_6490;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_TEST_RESET = 3'd1,
    OP_LOAD_IR    = 3'd2,
    OP_SEND_WORD  = 3'd3,
    OP_RECV_WORD  = 3'd4,
    OP_READ_ID    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CMD_IDLE       = 3'd0,
    CMD_TEST_RESET = 3'd1,
    CMD_LOAD_IR    = 3'd2,
    CMD_SEND_WORD  = 3'd3,
    CMD_RECV_WORD  = 3'd4,
    CMD_READ_ID    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ID_OK        = 2'd0,
    ID_BAD_MANUF = 2'd1,
    ID_BAD_PART  = 2'd2,
    ID_BAD_STEP  = 2'd3
  } id_status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] word_value;
    logic [4:0]  instruction;
    logic        tdo_level;
  } in_t;

  typedef struct packed {
    logic        tms_level;
    logic        tdi_level;
    logic        done_res;
    logic [31:0] data_word;
    logic [1:0]  id_status;
    logic [2:0]  stepping_index;
  } out_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } step_t;

  // supported stepping codes in index order
  function automatic step_t step_lookup(input logic [3:0] code);
    step_t r;
    r.hit = 1'b1;
    case (code)
      4'h0:    r.idx = 3'd0;
      4'h8:    r.idx = 3'd1;
      4'h4:    r.idx = 3'd2;
      4'hC:    r.idx = 3'd3;
      4'h2:    r.idx = 3'd4;
      4'hA:    r.idx = 3'd5;
      4'h6:    r.idx = 3'd6;
      default: begin
        r.hit = 1'b0;
        r.idx = 3'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// File: rtl/jtag_debug_word_master.sv
// jtag master shift engine: one tck period per tick transfer
//
//   channel  direction  payload  handshake
//   in       input      in_t     in_valid_i / in_stall_o
//   out      output     out_t    out_valid_o / out_stall_i
//   cfg      input      5 bits   cfg_we_i (idcode opcode)
//
// an item is processed from the input register when the result register is free, and
// its result is offered on the next cycle; one item per cycle while out_stall_i is low.
// the command sequencer and its phase counter update only on processed items.
// out_stall_i holds the result register, and the input register then raises in_stall_o.
// rst_ni clears the sequencer, the loaded-instruction cache and both valid bits.
module jtag_debug_word_master
  import jdw_pkg::*;
#(
  parameter int unsigned IR_LENGTH = IrLengthDefault,
  parameter int unsigned DATA_BITS = DataBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o
);

  // at least six bits so the 32-bit word bound fits
  localparam int unsigned PW = ($clog2(IR_LENGTH + DATA_BITS + 12) > 6) ?
                               $clog2(IR_LENGTH + DATA_BITS + 12) : 6;
  localparam int unsigned LoadTicks = IR_LENGTH + 6;

  localparam logic [PW-1:0] P1         = PW'(1);
  localparam logic [PW-1:0] P3         = PW'(3);
  localparam logic [PW-1:0] P4         = PW'(4);
  localparam logic [PW-1:0] P5         = PW'(5);
  localparam logic [PW-1:0] P6         = PW'(6);
  localparam logic [PW-1:0] IrLast     = PW'(IR_LENGTH + 3);
  localparam logic [PW-1:0] IrExit     = PW'(IR_LENGTH + 4);
  localparam logic [PW-1:0] IrEnd      = PW'(IR_LENGTH + 5);
  localparam logic [PW-1:0] LoadTicksP = PW'(LoadTicks);
  localparam logic [PW-1:0] DataBitsP  = PW'(DATA_BITS);
  localparam logic [PW-1:0] Word32     = PW'(32);

  // input register
  logic in_valid_q;
  in_t  in_q;
  // result register
  logic out_valid_q;
  out_t out_q;

  // sequencer state
  logic [4:0]    idcode_q;
  cmd_e          cmd_q, cmd_d;
  logic [PW-1:0] phase_q, phase_d;
  logic [31:0]   shift_q, shift_d;
  logic [5:0]    loaded_q, loaded_d;
  logic [4:0]    pending_q, pending_d;
  logic          busy_q, busy_d;

  logic out_free, fire;
  logic res_valid;
  out_t res;

  // per-tick helpers
  logic [PW-1:0] ir_idx, tx_idx, rx_idx, id_ph;
  logic          ir_bit, tx_bit;
  logic          ld_tms, ld_tdi, ld_last;
  logic          tms, tdi, done, retry;
  logic [31:0]   data;
  id_status_e    status;
  step_t         step;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idcode_q  <= IdcodeOpcodeReset;
      cmd_q     <= CMD_IDLE;
      phase_q   <= '0;
      shift_q   <= '0;
      loaded_q  <= InvalidInstr;
      pending_q <= '0;
      busy_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        idcode_q <= cfg_wdata_i;
      end
      cmd_q     <= cmd_d;
      phase_q   <= phase_d;
      shift_q   <= shift_d;
      loaded_q  <= loaded_d;
      pending_q <= pending_d;
      busy_q    <= busy_d;
    end
  end

  // bit selects for the instruction and data scans
  assign ir_idx = phase_q - P4;
  assign tx_idx = phase_q - P5;
  assign rx_idx = phase_q - P6;
  assign id_ph  = phase_q - LoadTicksP;
  assign ir_bit = (ir_idx < P5) ? pending_q[ir_idx[2:0]] : 1'b0;
  assign tx_bit = (tx_idx < Word32) ? shift_q[tx_idx[4:0]] : 1'b0;
  assign step   = step_lookup(shift_q[3:0]);

  // instruction register load: select-ir, capture, shift, exit, update
  always_comb begin
    ld_tms  = 1'b0;
    ld_tdi  = 1'b0;
    ld_last = 1'b0;
    if (phase_q <= P1) begin
      ld_tms = 1'b1;
    end else if (phase_q >= P4 && phase_q <= IrLast) begin
      ld_tms = (phase_q == IrLast);
      ld_tdi = ir_bit;
    end else if (phase_q == IrExit) begin
      ld_tms = 1'b1;
    end else if (phase_q >= IrEnd) begin
      ld_last = 1'b1;
    end
  end

  always_comb begin
    cmd_d     = cmd_q;
    phase_d   = phase_q;
    shift_d   = shift_q;
    loaded_d  = loaded_q;
    pending_d = pending_q;
    busy_d    = busy_q;
    res_valid = 1'b0;
    res       = '0;
    tms       = 1'b0;
    tdi       = 1'b0;
    done      = 1'b0;
    retry     = 1'b0;
    data      = '0;
    status    = ID_OK;

    if (fire) begin
      if (in_q.operation != OP_TICK) begin
        if (cmd_q == CMD_IDLE &&
            in_q.operation inside {[OP_TEST_RESET:OP_READ_ID]}) begin
          phase_d = '0;
          cmd_d   = cmd_e'(in_q.operation);
          case (in_q.operation)
            OP_LOAD_IR: begin
              pending_d = in_q.instruction;
              // already loaded: nothing to scan
              if ({1'b0, in_q.instruction} == loaded_q) begin
                cmd_d = CMD_IDLE;
              end
            end
            OP_SEND_WORD: begin
              shift_d = in_q.word_value;
              busy_d  = 1'b0;
            end
            OP_READ_ID: begin
              pending_d = idcode_q;
              shift_d   = '0;
              if ({1'b0, idcode_q} == loaded_q) begin
                phase_d = LoadTicksP;
              end
            end
            default: ;
          endcase
        end
      end else if (cmd_q != CMD_IDLE) begin
        res_valid = 1'b1;
        case (cmd_q)
          CMD_TEST_RESET: begin
            tms = 1'b1;
            if (phase_q >= P4) begin
              done     = 1'b1;
              loaded_d = InvalidInstr;
            end
          end
          CMD_LOAD_IR: begin
            tms  = ld_tms;
            tdi  = ld_tdi;
            done = ld_last;
            if (ld_last) begin
              loaded_d = {1'b0, pending_q};
            end
          end
          CMD_SEND_WORD: begin
            if (phase_q == '0) begin
              tms = 1'b1;
            end else if (phase_q == P3) begin
              // status bit high means the target still holds the last word
              busy_d = in_q.tdo_level;
              tms    = in_q.tdo_level;
            end else if (busy_q && phase_q == P4) begin
              tms = 1'b1;
            end else if (busy_q && phase_q >= P5) begin
              retry = 1'b1;
            end else if (phase_q >= P5 && phase_q < P5 + DataBitsP) begin
              tdi = tx_bit;
            end else if (phase_q == P5 + DataBitsP) begin
              tms = 1'b1;
              tdi = 1'b1;
            end else if (phase_q == P6 + DataBitsP) begin
              tms = 1'b1;
            end else if (phase_q > P6 + DataBitsP) begin
              done = 1'b1;
            end
          end
          CMD_RECV_WORD: begin
            if (phase_q == '0) begin
              tms     = 1'b1;
              shift_d = '0;
            end else if (phase_q == P3) begin
              busy_d = !in_q.tdo_level;
            end
            if (phase_q >= P6 && phase_q < P6 + DataBitsP && rx_idx < Word32 &&
                in_q.tdo_level) begin
              shift_d[rx_idx[4:0]] = 1'b1;
            end
            if (phase_q == P6 + DataBitsP || phase_q == P6 + DataBitsP + P1) begin
              tms = 1'b1;
            end
            if (phase_q > P6 + DataBitsP + P1) begin
              if (busy_q) begin
                retry = 1'b1;
              end else begin
                done = 1'b1;
                data = shift_q;
              end
            end
          end
          CMD_READ_ID: begin
            if (phase_q < LoadTicksP) begin
              tms = ld_tms;
              tdi = ld_tdi;
              if (ld_last) begin
                loaded_d = {1'b0, pending_q};
              end
            end else if (id_ph == '0) begin
              tms = 1'b1;
            end else if (id_ph >= P3 && id_ph < P3 + DataBitsP) begin
              shift_d = {shift_q[30:0], in_q.tdo_level};
            end else if (id_ph == P3 + DataBitsP || id_ph == P4 + DataBitsP) begin
              tms = 1'b1;
            end else if (id_ph >= P5 + DataBitsP) begin
              done = 1'b1;
              data = shift_q;
              if ((shift_q & ManufMask) != ManufValue) begin
                status = ID_BAD_MANUF;
              end else if ((shift_q & PartMask) != PartValue) begin
                status = ID_BAD_PART;
              end else if (!step.hit) begin
                status = ID_BAD_STEP;
              end
            end
          end
          default: ;
        endcase

        if (retry) begin
          phase_d = '0;
        end else if (done) begin
          cmd_d   = CMD_IDLE;
          phase_d = '0;
        end else begin
          phase_d = phase_q + P1;
        end

        if (!retry) begin
          res.tms_level      = tms;
          res.tdi_level      = tdi;
          res.done_res       = done;
          res.data_word      = data;
          res.id_status      = status;
          res.stepping_index = (done && cmd_q == CMD_READ_ID && status == ID_OK) ?
                               step.idx : 3'd0;
        end
      end
    end
  end

endmodule

// File: rtl/jdw_checker.sv
// port checker for the jtag debug word master, bound to the top level
`include "jtag_debug_word_master_assert.svh"

module jdw_checker
  import jdw_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled result holds
  `JDW_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // only a finished command reports data or id results
  `JDW_ASSERT(a_not_done_quiet, out_valid_o && !out_data_o.done_res |-> out_data_o.data_word == '0 && out_data_o.id_status == ID_OK && out_data_o.stepping_index == 3'd0)

  // a stepping index only comes with a good id and never exceeds the table
  `JDW_ASSERT(a_step_ok, out_valid_o |-> (out_data_o.stepping_index == 3'd0 || out_data_o.id_status == ID_OK) && out_data_o.stepping_index != 3'd7)

  // nothing is offered right after reset
  `JDW_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o)

endmodule

bind jtag_debug_word_master jdw_checker u_jdw_checker (.*);

// File: tb/sv/testbench.sv
// self-checking testbench for the jtag debug word master shift engine
module testbench
  import jdw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IrLen     = 5;
  localparam int unsigned DataLen   = 32;
  localparam int unsigned LoadTicks = IrLen + 6;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned WorkTarget = 1600;
  localparam int unsigned RandPhases = 5;
  localparam logic [2:0]  OpSpareLo = 3'd6;
  localparam logic [2:0]  OpSpareHi = 3'd7;
  // supported stepping codes, index 0 in the low nibble
  localparam logic [27:0] StepCodes = {4'h6, 4'hA, 4'h2, 4'hC, 4'h4, 4'h8, 4'h0};

  typedef enum int {
    ID_WORD_GOOD,
    ID_WORD_MANUF,
    ID_WORD_PART,
    ID_WORD_STEP
  } id_kind_e;

  typedef struct {
    cmd_e        cmd;
    int unsigned phase;
    logic [31:0] shreg;
    logic [5:0]  loaded_ir;
    logic [4:0]  pend_ir;
    logic        busy;
    logic [4:0]  id_op;
  } tap_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = IdcodeOpcodeReset;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  jtag_debug_word_master u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_t        tck_plan_q[$];
  out_t       expected_pins_q[$];
  tap_state_t plan_engine;
  tap_state_t check_engine;
  int unsigned cycles = 0;
  int unsigned planned_items = 0;
  int unsigned accepted_items = 0;
  int unsigned checked_results = 0;
  int unsigned scan_retries = 0;
  int unsigned cmd_count[8];
  int unsigned opcode_settings = 1;
  int unsigned errors = 0;
  logic calm;

  // long stretch without any idling on either side
  assign calm = (cycles % 6000) < 1200;

  function automatic void tap_reset_state(output tap_state_t s);
    s.cmd       = CMD_IDLE;
    s.phase     = 0;
    s.shreg     = '0;
    s.loaded_ir = InvalidInstr;
    s.pend_ir   = '0;
    s.busy      = 1'b0;
    s.id_op     = IdcodeOpcodeReset;
  endfunction

  // one tick of the instruction register scan, 1 on its last tick
  function automatic bit ir_scan_tick(inout tap_state_t s, input int unsigned p,
                                      output logic tms, output logic tdi);
    tms = 1'b0;
    tdi = 1'b0;
    if (p <= 1) begin
      tms = 1'b1;
    end else if (p >= 4 && p < 4 + IrLen) begin
      tms = (p - 4 == IrLen - 1);
      tdi = s.pend_ir[p - 4];
    end else if (p == 4 + IrLen) begin
      tms = 1'b1;
    end else if (p >= 5 + IrLen) begin
      s.loaded_ir = {1'b0, s.pend_ir};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advances the engine by one transfer, 1 when it yields a pin result
  function automatic bit tap_engine_step(inout tap_state_t s, input in_t it,
                                         output out_t r);
    int unsigned p;
    int unsigned q;
    logic tms;
    logic tdi;
    logic done;
    logic [31:0] data;
    id_status_e st;
    logic [2:0] sidx;
    p    = s.phase;
    tms  = 1'b0;
    tdi  = 1'b0;
    done = 1'b0;
    data = '0;
    st   = ID_OK;
    sidx = '0;
    r    = '0;
    if (it.operation != OP_TICK) begin
      if (s.cmd != CMD_IDLE || it.operation > OP_READ_ID) return 1'b0;
      s.phase = 0;
      case (it.operation)
        OP_LOAD_IR: begin
          s.pend_ir = it.instruction;
          if (s.loaded_ir == {1'b0, s.pend_ir}) return 1'b0;
        end
        OP_SEND_WORD: begin
          s.shreg = it.word_value;
          s.busy  = 1'b0;
        end
        OP_READ_ID: begin
          s.pend_ir = s.id_op;
          s.shreg   = '0;
          if (s.loaded_ir == {1'b0, s.pend_ir}) s.phase = LoadTicks;
        end
        default: ;
      endcase
      s.cmd = cmd_e'(it.operation);
      return 1'b0;
    end
    if (s.cmd == CMD_IDLE) return 1'b0;

    case (s.cmd)
      CMD_TEST_RESET: begin
        tms = 1'b1;
        if (p >= 4) begin
          done = 1'b1;
          s.loaded_ir = InvalidInstr;
        end
      end
      CMD_LOAD_IR: done = ir_scan_tick(s, p, tms, tdi);
      CMD_SEND_WORD: begin
        if (p == 0) begin
          tms = 1'b1;
        end else if (p == 3) begin
          s.busy = it.tdo_level;
          tms    = it.tdo_level;
        end else if (s.busy && p == 4) begin
          tms = 1'b1;
        end else if (s.busy && p >= 5) begin
          // target busy: leave the scan and start over
          s.phase = 0;
          return 1'b1;
        end else if (p >= 5 && p < 5 + DataLen) begin
          tdi = s.shreg[p - 5];
        end else if (p == 5 + DataLen) begin
          tms = 1'b1;
          tdi = 1'b1;
        end else if (p == 6 + DataLen) begin
          tms = 1'b1;
        end else if (p >= 7 + DataLen) begin
          done = 1'b1;
        end
      end
      CMD_RECV_WORD: begin
        if (p == 0) begin
          tms     = 1'b1;
          s.shreg = '0;
        end else if (p == 3) begin
          s.busy = !it.tdo_level;
        end
        if (p >= 6 && p < 6 + DataLen && it.tdo_level) s.shreg[p - 6] = 1'b1;
        if (p == 6 + DataLen || p == 7 + DataLen) tms = 1'b1;
        if (p >= 8 + DataLen) begin
          if (s.busy) begin
            s.phase = 0;
            return 1'b1;
          end
          done = 1'b1;
          data = s.shreg;
        end
      end
      default: begin
        if (p < LoadTicks) begin
          void'(ir_scan_tick(s, p, tms, tdi));
        end else begin
          q = p - LoadTicks;
          if (q == 0) begin
            tms = 1'b1;
          end else if (q >= 3 && q < 3 + DataLen) begin
            s.shreg = {s.shreg[30:0], it.tdo_level};
          end else if (q == 3 + DataLen || q == 4 + DataLen) begin
            tms = 1'b1;
          end else if (q >= 5 + DataLen) begin
            done = 1'b1;
            data = s.shreg;
            if ((s.shreg & ManufMask) != ManufValue) begin
              st = ID_BAD_MANUF;
            end else if ((s.shreg & PartMask) != PartValue) begin
              st = ID_BAD_PART;
            end else begin
              st = ID_BAD_STEP;
              for (int k = 0; k < 7; k++) begin
                if (StepCodes[k*4 +: 4] == s.shreg[3:0]) begin
                  st   = ID_OK;
                  sidx = 3'(k);
                end
              end
            end
          end
        end
      end
    endcase

    if (done) begin
      s.cmd   = CMD_IDLE;
      s.phase = 0;
    end else begin
      s.phase = p + 1;
    end
    r.tms_level      = tms;
    r.tdi_level      = tdi;
    r.done_res       = done;
    r.data_word      = data;
    r.id_status      = st;
    r.stepping_index = sidx;
    return 1'b1;
  endfunction

  function automatic in_t random_item(input logic [2:0] op);
    in_t it;
    it.operation   = op;
    it.word_value  = $urandom;
    it.instruction = 5'($urandom_range(0, 31));
    it.tdo_level   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic plan_item(input in_t it);
    out_t r;
    void'(tap_engine_step(plan_engine, it, r));
    tck_plan_q.push_back(it);
    planned_items++;
  endtask

  function automatic logic [31:0] make_id_word(input id_kind_e kind);
    logic [31:0] w;
    w = ManufValue | PartValue | 32'(StepCodes[$urandom_range(0, 6)*4 +: 4]);
    case (kind)
      ID_WORD_MANUF: w = w ^ ({$urandom_range(1, 4095)} << 20);
      ID_WORD_PART:  w = w ^ (32'($urandom_range(1, 65535)) << 4);
      ID_WORD_STEP:  w[3:0] = $urandom_range(0, 1) ? 4'hF : 4'h1 | 4'($urandom_range(0, 14));
      default: ;
    endcase
    return w;
  endfunction

  // a command followed by the ticks that carry it to its end
  task automatic run_command(input logic [2:0] op, input logic [31:0] word,
                             input logic [4:0] instr, input logic [31:0] id_word,
                             input int polls, input int noise_pct);
    in_t it;
    int unsigned p;
    int polls_left;
    int guard;
    it = random_item(op);
    it.word_value  = word;
    it.instruction = instr;
    plan_item(it);
    if (plan_engine.cmd == CMD_IDLE) return;
    cmd_count[op]++;
    polls_left = polls;
    guard = 0;
    while (plan_engine.cmd != CMD_IDLE && guard < 4000) begin
      guard++;
      if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct) begin
        // command while busy, dropped by the engine
        plan_item(random_item(3'($urandom_range(1, 7))));
      end else begin
        it = random_item(OP_TICK);
        p  = plan_engine.phase;
        case (plan_engine.cmd)
          CMD_SEND_WORD: if (p == 3) begin
            it.tdo_level = (polls_left > 0);
            if (polls_left > 0) begin
              polls_left--;
              scan_retries++;
            end
          end
          CMD_RECV_WORD: if (p == 3) begin
            it.tdo_level = (polls_left == 0);
            if (polls_left > 0) begin
              polls_left--;
              scan_retries++;
            end
          end
          CMD_READ_ID: if (p >= LoadTicks + 3 && p < LoadTicks + 3 + DataLen) begin
            it.tdo_level = id_word[LoadTicks + 2 + DataLen - p];
          end
          default: ;
        endcase
        plan_item(it);
      end
    end
  endtask

  task automatic wait_drained();
    while (accepted_items != planned_items || expected_pins_q.size() != 0)
      @(posedge clk_i);
    // items that yield no result may still sit in the pipeline
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_idcode_opcode(input logic [4:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    plan_engine.id_op  = v;
    check_engine.id_op = v;
    opcode_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned goal);
    logic [2:0] op;
    logic [4:0] instr;
    logic [31:0] word;
    int polls;
    int pick;
    while (planned_items < goal) begin
      if ($urandom_range(0, 99) < 10) begin
        // tick while idle or a spare operation code
        pick = $urandom_range(0, 2);
        op = (pick == 0) ? OP_TICK : (pick == 1) ? OpSpareLo : OpSpareHi;
        plan_item(random_item(op));
      end
      op = 3'($urandom_range(OP_TEST_RESET, OP_READ_ID));
      pick = $urandom_range(0, 99);
      instr = (pick < 30) ? plan_engine.loaded_ir[4:0] :
              (pick < 50) ? plan_engine.id_op : 5'($urandom_range(0, 31));
      pick = $urandom_range(0, 19);
      word = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      polls = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      run_command(op, word, instr, make_id_word(id_kind_e'($urandom_range(0, 3))),
                  polls, 3);
    end
  endtask

  // sender side: one transfer per accepted cycle, random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (tck_plan_q.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= tck_plan_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver side stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 22);
    end
  end

  // predicts the pin levels for every accepted input transfer
  always @(posedge clk_i) begin
    out_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (tap_engine_step(check_engine, in_data_i, r)) expected_pins_q.push_back(r);
      accepted_items++;
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pins_q.size() == 0) begin
        if (errors < 10) $display("%0t: unexpected result transfer %p", $realtime, out_data_o);
        errors++;
      end else begin
        want = expected_pins_q.pop_front();
        checked_results++;
        if (out_data_o.tms_level !== want.tms_level ||
            out_data_o.tdi_level !== want.tdi_level ||
            out_data_o.done_res !== want.done_res ||
            out_data_o.data_word !== want.data_word ||
            out_data_o.id_status !== want.id_status ||
            out_data_o.stepping_index !== want.stepping_index) begin
          if (errors < 10) begin
            $display("%0t: mismatch on result %0d", $realtime, checked_results);
            $display("  expected tms %b tdi %b done %b data %h status %0d step %0d",
                     want.tms_level, want.tdi_level, want.done_res, want.data_word,
                     want.id_status, want.stepping_index);
            $display("  actual   tms %b tdi %b done %b data %h status %0d step %0d",
                     out_data_o.tms_level, out_data_o.tdi_level, out_data_o.done_res,
                     out_data_o.data_word, out_data_o.id_status,
                     out_data_o.stepping_index);
          end
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_pins_q.size());
      $display("jtag_debug_word_master test failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] id_good;
    int unsigned base_items;
    id_good = ManufValue | PartValue | 32'hA;
    tap_reset_state(plan_engine);
    tap_reset_state(check_engine);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, default identification opcode
    plan_item(random_item(OP_TICK));
    plan_item(random_item(OpSpareLo));
    plan_item(random_item(OpSpareHi));
    run_command(OP_TEST_RESET, '0, '0, '0, 0, 0);
    run_command(OP_LOAD_IR, '0, 5'd0, '0, 0, 0);
    run_command(OP_LOAD_IR, '0, 5'd0, '0, 0, 0);
    run_command(OP_LOAD_IR, '0, 5'd31, '0, 0, 0);
    run_command(OP_SEND_WORD, 32'h0, '0, '0, 0, 0);
    run_command(OP_SEND_WORD, 32'hFFFF_FFFF, '0, '0, 2, 5);
    run_command(OP_RECV_WORD, '0, '0, '0, 0, 0);
    run_command(OP_RECV_WORD, '0, '0, '0, 1, 0);
    run_command(OP_READ_ID, '0, '0, id_good, 0, 0);
    run_command(OP_READ_ID, '0, '0, make_id_word(ID_WORD_MANUF), 0, 0);
    run_command(OP_READ_ID, '0, '0, make_id_word(ID_WORD_PART), 0, 0);
    run_command(OP_READ_ID, '0, '0, make_id_word(ID_WORD_STEP), 0, 0);
    run_command(OP_TEST_RESET, '0, '0, '0, 0, 0);
    run_command(OP_READ_ID, '0, '0, 32'hC802_6490, 0, 0);
    run_command(OP_LOAD_IR, '0, IdcodeOpcodeReset, '0, 0, 0);
    // random phases share what is left of the item budget
    base_items = planned_items;
    random_phase(base_items + (WorkTarget - base_items) / (RandPhases + 1));
    wait_drained();

    for (int ph = 0; ph < RandPhases; ph++) begin
      write_idcode_opcode((ph == 0) ? 5'd0 : (ph == 1) ? 5'd31 : 5'($urandom_range(0, 31)));
      random_phase(base_items + (WorkTarget - base_items) * (ph + 2) / (RandPhases + 1));
      wait_drained();
    end
    repeat (20) @(posedge clk_i);
    errors += expected_pins_q.size();

    $display("checked %0d pin results from %0d transfers, %0d scan retries",
             checked_results, accepted_items, scan_retries);
    $display("commands reset/load/send/recv/id %0d/%0d/%0d/%0d/%0d, %0d opcode settings",
             cmd_count[OP_TEST_RESET], cmd_count[OP_LOAD_IR], cmd_count[OP_SEND_WORD],
             cmd_count[OP_RECV_WORD], cmd_count[OP_READ_ID], opcode_settings);
    if (errors == 0) begin
      $display("jtag_debug_word_master test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("jtag_debug_word_master test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/jdw_pkg.sv
rtl/jtag_debug_word_master.sv
rtl/jdw_checker.sv
tb/sv/testbench.sv
